### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each expects signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PJQA_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PJQA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/pjqa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjqa_pkg
// Types and constants of the priority job queue with admission.
// ----------------------------------------------------------------------------
package pjqa_pkg;

   localparam int QUEUE_DEPTH     = 128;
   localparam int JOB_COUNT       = 2;
   // only two jobs carry configuration registers
   localparam int CONFIGURED_JOBS = 2;

   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
   localparam int PRIO_W   = 8;
   localparam int JOB_ID_W = 8;
   localparam int LIMIT_W  = 8;
   localparam int OUT_CNT_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [1:0] {
      CMD_INIT   = 2'd0,
      CMD_SUBMIT = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK            = 3'd0,
      STAT_UNINIT        = 3'd1,
      STAT_BAD_POINTER   = 3'd2,
      STAT_BAD_HANDLE    = 3'd3,
      STAT_WRONG_SERVICE = 3'd4,
      STAT_FULL          = 3'd5,
      STAT_EMPTY         = 3'd6
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PRIO   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_PRIO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SVC    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_SVC   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT  = 3'd4;

   localparam logic SVC_GENERATE = 1'b0;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } fsm_state_type;

   typedef struct packed {
      logic capture;
      logic clear_queue;
      logic insert;
      logic pop;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    admit;
      logic    empty;
   } dp_status_type;

endpackage

### hw/rtl/pjqa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjqa_if
// Request and response channels of the job queue.
// ----------------------------------------------------------------------------
interface pjqa_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] job_id;
   logic       buffers_valid;

   modport source (output valid, output command, output job_id,
                   output buffers_valid, input ready);
   modport sink   (input valid, input command, input job_id,
                   input buffers_valid, output ready);
endinterface

interface pjqa_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       popped_valid;
   logic       popped_job;
   logic [7:0] popped_priority;
   logic [7:0] queue_count;

   modport source (output valid, output status, output popped_valid,
                   output popped_job, output popped_priority,
                   output queue_count, input ready);
   modport sink   (input valid, input status, input popped_valid,
                   input popped_job, input popped_priority,
                   input queue_count, output ready);
endinterface

### hw/rtl/priority_job_queue_with_admission.sv
`timescale 1ns / 1ps
// Each command word is handled in two states: it is captured in S_IDLE, then
// S_EXEC runs the admission checks and updates the queue. A submit is inserted
// in the execute step by a row of QUEUE_DEPTH compare-and-shift cells. A new
// word is taken only once the previous one has left the execute state; the
// next request is accepted while the previous result still waits, and the
// execute step waits only if that result has not been taken yet.
// ----------------------------------------------------------------------------
// priority_job_queue_with_admission
// Priority job queue with init, submit and tick commands.
// ----------------------------------------------------------------------------
module priority_job_queue_with_admission
   import pjqa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   pjqa_req_if.sink              req_chan,
   pjqa_rsp_if.source            rsp_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_stat;
   logic          req_ready;
   logic          rsp_valid;

   pjqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   pjqa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_command         (req_chan.command),
      .req_job_id          (req_chan.job_id),
      .req_buffers_valid   (req_chan.buffers_valid),
      .cmd                 (cmd),
      .dp_stat             (dp_stat),
      .rsp_status          (rsp_chan.status),
      .rsp_popped_valid    (rsp_chan.popped_valid),
      .rsp_popped_job      (rsp_chan.popped_job),
      .rsp_popped_priority (rsp_chan.popped_priority),
      .rsp_queue_count     (rsp_chan.queue_count)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

### hw/rtl/pjqa_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pjqa_ctrl
// Sequencer: captures a request word, then executes it and loads the result.
// ----------------------------------------------------------------------------
module pjqa_ctrl
   import pjqa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_stat,
   output ctrl_cmd_type  cmd
);

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the previous result word has left
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
               unique case (dp_stat.cmd)
                  CMD_INIT:   cmd.clear_queue = 1'b1;
                  CMD_SUBMIT: cmd.insert      = dp_stat.admit;
                  CMD_TICK:   cmd.pop         = !dp_stat.empty;
                  CMD_NONE:   ;
               endcase
            end
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   `PJQA_ASSERT_NEXT(a_capture_to_exec, req_valid && req_ready, state_ff == S_EXEC, "capture did not enter execute")
   `PJQA_ASSERT_NEXT(a_load_shows_rsp, cmd.load_rsp, rsp_valid_ff, "loaded result not presented")
   `PJQA_ASSERT(a_single_queue_op, 1'b1, $onehot0({cmd.clear_queue, cmd.insert, cmd.pop}), "conflicting queue operations")

endmodule

### hw/rtl/pjqa_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pjqa_datapath
// Config registers, admission checks, sorted cell row and result register.
// ----------------------------------------------------------------------------
module pjqa_datapath
   import pjqa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [1:0]            req_command,
   input  logic [JOB_ID_W-1:0]   req_job_id,
   input  logic                  req_buffers_valid,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         dp_stat,
   output logic [2:0]            rsp_status,
   output logic                  rsp_popped_valid,
   output logic                  rsp_popped_job,
   output logic [PRIO_W-1:0]     rsp_popped_priority,
   output logic [OUT_CNT_W-1:0]  rsp_queue_count
);

   // configuration
   logic [PRIO_W-1:0]  prio0_ff, prio1_ff;
   logic               svc0_ff, svc1_ff;
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prio0_ff <= PRIO_W'(1);
         prio1_ff <= PRIO_W'(2);
         svc0_ff  <= 1'b0;
         svc1_ff  <= 1'b1;
         limit_ff <= LIMIT_W'(128);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_PRIO:  prio0_ff <= csr_wdata[PRIO_W-1:0];
            CSR_SECOND_PRIO: prio1_ff <= csr_wdata[PRIO_W-1:0];
            CSR_FIRST_SVC:   svc0_ff  <= csr_wdata[0];
            CSR_SECOND_SVC:  svc1_ff  <= csr_wdata[0];
            CSR_QUEUE_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // captured request word
   cmd_type             cmd_ff;
   logic [JOB_ID_W-1:0] job_ff;
   logic                bufs_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= cmd_type'(req_command);
         job_ff  <= req_job_id;
         bufs_ff <= req_buffers_valid;
      end
   end

   // queue control state
   logic             init_ff, init_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         init_ff  <= init_in;
         count_ff <= count_in;
      end
   end

   assign init_in = init_ff | cmd.clear_queue;

   always_comb begin
      priority if (cmd.clear_queue) count_in = '0;
      else if (cmd.insert)          count_in = count_ff + CNT_W'(1);
      else if (cmd.pop)             count_in = count_ff - CNT_W'(1);
      else                          count_in = count_ff;
   end

   // admission checks
   logic              new_job;
   logic [PRIO_W-1:0] new_prio;
   logic              new_svc;
   logic              full;
   status_type        sub_status;

   assign new_job  = job_ff[0];
   assign new_prio = new_job ? prio1_ff : prio0_ff;
   assign new_svc  = new_job ? svc1_ff : svc0_ff;
   assign full     = (CMP_W'(count_ff) >= CMP_W'(limit_ff))
                   || (count_ff >= CNT_W'(QUEUE_DEPTH));

   always_comb begin
      priority if (!init_ff)                                 sub_status = STAT_UNINIT;
      else if (!bufs_ff)                                     sub_status = STAT_BAD_POINTER;
      else if (({1'b0, job_ff} >= (JOB_ID_W + 1)'(JOB_COUNT))
               || ({1'b0, job_ff} >= (JOB_ID_W + 1)'(CONFIGURED_JOBS)))
                                                             sub_status = STAT_BAD_HANDLE;
      else if (new_svc != SVC_GENERATE)                      sub_status = STAT_WRONG_SERVICE;
      else if (full)                                         sub_status = STAT_FULL;
      else                                                   sub_status = STAT_OK;
   end

   assign dp_stat.cmd   = cmd_ff;
   assign dp_stat.admit = (sub_status == STAT_OK);
   assign dp_stat.empty = (count_ff == '0);

   // sorted cell row, index 0 is the front
   logic              cell_job_ff  [QUEUE_DEPTH];
   logic [PRIO_W-1:0] cell_prio_ff [QUEUE_DEPTH];
   logic              cell_job_in  [QUEUE_DEPTH];
   logic [PRIO_W-1:0] cell_prio_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] take_slot;

   // a cell takes part in the shift if it holds a lower priority or is free;
   // the row is sorted so take_slot is a thermometer code
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         take_slot[i] = (CNT_W'(i) < count_ff) ? (new_prio > cell_prio_ff[i]) : 1'b1;
      end
   end

   always_comb begin
      cell_job_in  = cell_job_ff;
      cell_prio_in = cell_prio_ff;
      if (cmd.insert) begin
         if (take_slot[0]) begin
            cell_job_in[0]  = new_job;
            cell_prio_in[0] = new_prio;
         end
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (take_slot[i]) begin
               cell_job_in[i]  = take_slot[i-1] ? cell_job_ff[i-1]  : new_job;
               cell_prio_in[i] = take_slot[i-1] ? cell_prio_ff[i-1] : new_prio;
            end
         end
      end else if (cmd.pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            cell_job_in[i]  = cell_job_ff[i+1];
            cell_prio_in[i] = cell_prio_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_job_ff  <= cell_job_in;
      cell_prio_ff <= cell_prio_in;
   end

   // result word
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_pv_ff;
   logic                 rsp_pj_ff;
   logic [PRIO_W-1:0]    rsp_pp_ff;
   logic [OUT_CNT_W-1:0] rsp_cnt_ff;
   logic [CMP_W-1:0]     count_ext;

   assign count_ext = CMP_W'(count_in);

   always_comb begin
      unique case (cmd_ff)
         CMD_INIT:   rsp_status_in = STAT_OK;
         CMD_SUBMIT: rsp_status_in = sub_status;
         CMD_TICK:   rsp_status_in = dp_stat.empty ? STAT_EMPTY : STAT_OK;
         CMD_NONE:   rsp_status_in = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pv_ff     <= cmd.pop;
         rsp_pj_ff     <= cmd.pop & cell_job_ff[0];
         rsp_pp_ff     <= cmd.pop ? cell_prio_ff[0] : '0;
         rsp_cnt_ff    <= count_ext[OUT_CNT_W-1:0];
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_popped_valid    = rsp_pv_ff;
   assign rsp_popped_job      = rsp_pj_ff;
   assign rsp_popped_priority = rsp_pp_ff;
   assign rsp_queue_count     = rsp_cnt_ff;

   `PJQA_ASSERT(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "entry count beyond depth")
   `PJQA_ASSERT(a_head_sorted, count_ff >= CNT_W'(2), cell_prio_ff[0] >= cell_prio_ff[1], "front entries out of order")
   `PJQA_ASSERT_NEXT(a_insert_grows, cmd.insert, count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow queue")

endmodule

### tb/sv/tb_priority_job_queue_with_admission.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_job_queue_with_admission
// Self-checking bench for the priority job queue with admission checks.
// A driver feeds command words in random bursts and a monitor checks every
// response word against an in-bench model of the sorted queue. The registers
// are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_priority_job_queue_with_admission;
   import pjqa_pkg::*;

   localparam int RUN_LIMIT = 400000;
   localparam int MAX_PRINTS = 40;

   typedef struct packed {
      cmd_type             command;
      logic [JOB_ID_W-1:0] job_id;
      logic                buffers_valid;
   } job_word_type;

   typedef struct packed {
      status_type           status;
      logic                 popped_valid;
      logic                 popped_job;
      logic [PRIO_W-1:0]    popped_priority;
      logic [OUT_CNT_W-1:0] queue_count;
   } job_outcome_type;

   typedef enum logic [1:0] {
      FLOW_FREE, FLOW_RANDOM, FLOW_PATTERN, FLOW_HOLD
   } flow_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pjqa_req_if req_bus ();
   pjqa_rsp_if rsp_bus ();

   priority_job_queue_with_admission uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #10 clock = ~clock;

   // queue model: registers and sorted store, index 0 is the front
   logic [PRIO_W-1:0] job_priority [CONFIGURED_JOBS] = '{8'd1, 8'd2};
   logic              job_service  [CONFIGURED_JOBS] = '{1'b0, 1'b1};
   int                queue_limit = 128;
   logic              queue_open = 1'b0;
   logic              held_job  [QUEUE_DEPTH];
   logic [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
   int                held_count = 0;

   job_word_type    job_words [$];
   job_outcome_type awaited_outcomes [$];
   job_word_type    word_on_bus;

   int words_issued = 0;
   int words_accepted = 0;
   int outcomes_checked = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int admitted_count = 0;
   int pop_count = 0;
   int full_count = 0;
   int reject_count = 0;
   int peak_held = 0;

   // sender pacing
   int   burst_left = 4;
   int   gap_left = 0;
   logic draining = 1'b0;
   int   drains_seen = 0;

   // receiver pacing
   flow_mode_type flow_mode = FLOW_FREE;
   int            flow_span = 0;
   logic [7:0]    flow_pattern = 8'hff;

   function automatic job_outcome_type apply_job_command(job_word_type w);
      job_outcome_type o;
      int cap;
      int slot;
      logic [PRIO_W-1:0] prio;
      o = '0;
      o.status = STAT_OK;
      case (w.command)
         CMD_INIT: begin
            held_count = 0;
            queue_open = 1'b1;
         end
         CMD_SUBMIT: begin
            cap = (queue_limit < QUEUE_DEPTH) ? queue_limit : QUEUE_DEPTH;
            if (!queue_open) begin
               o.status = STAT_UNINIT;
            end else if (!w.buffers_valid) begin
               o.status = STAT_BAD_POINTER;
            end else if (w.job_id >= JOB_COUNT || w.job_id >= CONFIGURED_JOBS) begin
               o.status = STAT_BAD_HANDLE;
            end else if (job_service[w.job_id[0]] != SVC_GENERATE) begin
               o.status = STAT_WRONG_SERVICE;
            end else if (held_count >= cap) begin
               o.status = STAT_FULL;
               full_count++;
            end else begin
               prio = job_priority[w.job_id[0]];
               // goes ahead of the first strictly lower priority
               slot = held_count;
               for (int k = 0; k < held_count; k++)
                  if (slot == held_count && prio > held_prio[k]) slot = k;
               for (int k = held_count; k > slot; k--) begin
                  held_job[k]  = held_job[k-1];
                  held_prio[k] = held_prio[k-1];
               end
               held_job[slot]  = w.job_id[0];
               held_prio[slot] = prio;
               held_count++;
               admitted_count++;
               if (held_count > peak_held) peak_held = held_count;
            end
            if (o.status != STAT_OK && o.status != STAT_FULL) reject_count++;
         end
         CMD_TICK: begin
            if (held_count == 0) begin
               o.status = STAT_EMPTY;
            end else begin
               o.popped_valid    = 1'b1;
               o.popped_job      = held_job[0];
               o.popped_priority = held_prio[0];
               for (int k = 1; k < held_count; k++) begin
                  held_job[k-1]  = held_job[k];
                  held_prio[k-1] = held_prio[k];
               end
               held_count--;
               pop_count++;
            end
         end
         default: ;
      endcase
      o.queue_count = held_count[OUT_CNT_W-1:0];
      return o;
   endfunction

   task automatic report_mismatch(string what);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("[%0t] response %0d: %s", $time, outcomes_checked, what);
   endtask

   // driver: one nonblocking write of valid per edge, unless a word is stalled
   always @(posedge clock) begin
      logic send;
      send = 1'b0;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid) begin
            awaited_outcomes.push_back(apply_job_command(word_on_bus));
            words_accepted++;
         end
         if (draining && awaited_outcomes.size() == 0) begin
            draining = 1'b0;
            drains_seen++;
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (!draining && job_words.size() != 0) begin
            send = 1'b1;
            word_on_bus = job_words.pop_front();
            req_bus.command       <= word_on_bus.command;
            req_bus.job_id        <= word_on_bus.job_id;
            req_bus.buffers_valid <= word_on_bus.buffers_valid;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               // now and then hold off until the queue of answers runs dry
               if ($urandom_range(0, 29) == 0 || (drains_seen == 0 && words_accepted > 300))
                  draining = 1'b1;
            end
         end
         req_bus.valid <= send;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      logic take;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (flow_span == 0) begin
            flow_mode    = flow_mode_type'($urandom_range(0, 3));
            flow_span    = $urandom_range(8, 60);
            flow_pattern = 8'($urandom_range(1, 255));
         end
         flow_span--;
         case (flow_mode)
            FLOW_FREE:   take = 1'b1;
            FLOW_RANDOM: take = ($urandom_range(0, 3) != 0);
            FLOW_PATTERN: begin
               take = flow_pattern[0];
               flow_pattern = {flow_pattern[0], flow_pattern[7:1]};
            end
            default:     take = (flow_span < 4);
         endcase
         rsp_bus.ready <= take;
      end
   end

   // monitor
   always @(posedge clock) begin
      job_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch($sformatf("word with nothing pending, status %0d", rsp_bus.status));
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_bus.status, want.status));
            if (rsp_bus.popped_valid !== want.popped_valid)
               report_mismatch($sformatf("popped_valid %0b, want %0b",
                                         rsp_bus.popped_valid, want.popped_valid));
            if (rsp_bus.popped_job !== want.popped_job)
               report_mismatch($sformatf("popped_job %0b, want %0b",
                                         rsp_bus.popped_job, want.popped_job));
            if (rsp_bus.popped_priority !== want.popped_priority)
               report_mismatch($sformatf("popped_priority %0d, want %0d",
                                         rsp_bus.popped_priority, want.popped_priority));
            if (rsp_bus.queue_count !== want.queue_count)
               report_mismatch($sformatf("queue_count %0d, want %0d",
                                         rsp_bus.queue_count, want.queue_count));
            outcomes_checked++;
         end
      end
   end

   always @(posedge clock) cycle_count++;

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("timeout after %0d cycles, %0d of %0d words answered",
               cycle_count, outcomes_checked, words_issued);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic queue_word(cmd_type c, logic [JOB_ID_W-1:0] job, logic bufs);
      job_words.push_back('{command: c, job_id: job, buffers_valid: bufs});
      words_issued++;
   endtask

   task automatic wait_idle();
      while (outcomes_checked < words_issued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_FIRST_PRIO:  job_priority[0] = value[PRIO_W-1:0];
         CSR_SECOND_PRIO: job_priority[1] = value[PRIO_W-1:0];
         CSR_FIRST_SVC:   job_service[0]  = value[0];
         CSR_SECOND_SVC:  job_service[1]  = value[0];
         CSR_QUEUE_LIMIT: queue_limit     = value & 8'hff;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_queue_regs(int limit, int p0, int p1, logic s0, logic s1);
      write_reg(CSR_FIRST_PRIO, p0);
      write_reg(CSR_SECOND_PRIO, p1);
      write_reg(CSR_FIRST_SVC, s0);
      write_reg(CSR_SECOND_SVC, s1);
      write_reg(CSR_QUEUE_LIMIT, limit);
   endtask

   function automatic int pick_priority();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 255;
      return $urandom_range(0, 255);
   endfunction

   // starts with an init, then mostly well-formed submits and ticks
   task automatic queue_phase(int n, int submit_pct, int init_pct);
      int r;
      logic [JOB_ID_W-1:0] job;
      queue_word(CMD_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < n; i++) begin
         r   = $urandom_range(0, 99);
         job = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 1));
         if (r < init_pct)
            queue_word(CMD_INIT, job, 1'($urandom_range(0, 1)));
         else if (r < init_pct + 2)
            queue_word(CMD_NONE, job, 1'($urandom_range(0, 1)));
         else if (r < init_pct + 2 + submit_pct)
            queue_word(CMD_SUBMIT, job, ($urandom_range(0, 15) != 0));
         else
            queue_word(CMD_TICK, job, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int limit;
      int p0;
      int p1;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_NONE;
      req_bus.job_id = '0;
      req_bus.buffers_valid = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset values: job 1 is not a generate job
      queue_word(CMD_TICK, 8'd0, 1'b1);     // empty before init
      queue_word(CMD_SUBMIT, 8'd0, 1'b1);   // not yet initialized
      queue_word(CMD_NONE, 8'haa, 1'b1);
      queue_word(CMD_INIT, 8'h55, 1'b0);
      queue_word(CMD_SUBMIT, 8'd0, 1'b0);   // null buffers
      queue_word(CMD_SUBMIT, 8'd2, 1'b1);   // handle out of range
      queue_word(CMD_SUBMIT, 8'hff, 1'b1);
      queue_word(CMD_SUBMIT, 8'd1, 1'b1);   // wrong service
      queue_word(CMD_SUBMIT, 8'd0, 1'b1);
      queue_word(CMD_TICK, 8'd0, 1'b0);
      queue_word(CMD_TICK, 8'd0, 1'b0);
      queue_word(CMD_SUBMIT, 8'd0, 1'b1);
      queue_word(CMD_INIT, 8'd0, 1'b1);     // re-init empties the queue
      wait_idle();

      set_queue_regs(3, 0, 255, 1'b0, 1'b0);
      queue_word(CMD_SUBMIT, 8'd0, 1'b1);
      queue_word(CMD_SUBMIT, 8'd1, 1'b1);   // jumps to the front
      queue_word(CMD_SUBMIT, 8'd0, 1'b1);
      queue_word(CMD_SUBMIT, 8'd1, 1'b1);   // full at the limit
      queue_word(CMD_TICK, 8'd0, 1'b1);
      queue_word(CMD_TICK, 8'd0, 1'b1);
      queue_word(CMD_TICK, 8'd0, 1'b1);
      wait_idle();

      set_queue_regs(0, 255, 255, 1'b0, 1'b0);
      queue_word(CMD_SUBMIT, 8'd0, 1'b1);   // zero limit is always full
      wait_idle();

      set_queue_regs(255, 255, 255, 1'b1, 1'b0);
      queue_word(CMD_SUBMIT, 8'd0, 1'b1);
      queue_word(CMD_SUBMIT, 8'd1, 1'b1);
      wait_idle();
      write_reg(CSR_FIRST_SVC, 0);
      queue_word(CMD_SUBMIT, 8'd0, 1'b1);   // equal priority stays behind
      queue_word(CMD_TICK, 8'd0, 1'b1);
      queue_word(CMD_TICK, 8'd0, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       limit = 128;
            1:       limit = 255;
            2:       limit = 1;
            3:       limit = 0;
            4:       limit = 2;
            6:       limit = 128;
            default: limit = $urandom_range(3, 127);
         endcase
         p0 = pick_priority();
         p1 = (phase % 3 == 1) ? p0 : pick_priority();
         if (phase == 0)
            set_queue_regs(limit, p0, p1, 1'b0, 1'b0);
         else
            set_queue_regs(limit, p0, p1, ($urandom_range(0, 6) == 0),
                           ($urandom_range(0, 6) == 0));
         if (phase == 0)
            queue_phase(260, 88, 0);       // fills to the full depth
         else if (limit == 0)
            queue_phase(60, 50, 2);
         else
            queue_phase(115, 55, 2);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      $display("covered %0d words: %0d admitted, %0d popped, %0d full, %0d rejected",
               words_accepted, admitted_count, pop_count, full_count, reject_count);
      $display("deepest queue %0d entries, %0d sender holds until drained",
               peak_held, drains_seen);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pjqa_pkg.sv
hw/rtl/pjqa_if.sv
hw/rtl/pjqa_ctrl.sv
hw/rtl/pjqa_datapath.sv
hw/rtl/priority_job_queue_with_admission.sv
tb/sv/tb_priority_job_queue_with_admission.sv
